// File: hdl/protobuf_wire_field_parser_top_defines.svh
// Assertion macros shared by the parser's top level.
`ifndef PROTOBUF_WIRE_FIELD_PARSER_TOP_DEFINES_SVH
`define PROTOBUF_WIRE_FIELD_PARSER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PWF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent.
`define PWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: hdl/pwf_pkg.sv
// ----------------------------------------------------------------------------
// pwf_pkg
// Types and constants shared by the protobuf wire field parser.
// ----------------------------------------------------------------------------
package pwf_pkg;
    localparam int unsigned LEN_W      = 17;
    localparam int unsigned MAX_MSG    = 65536;
    localparam int unsigned VARINT_MAX = 10;
    localparam int unsigned QDEPTH     = 2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO_FN = 2'd1;
    localparam logic [1:0] ST_BAD_WT  = 2'd2;
    localparam logic [1:0] ST_LEN_END = 2'd3;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    localparam logic [0:0] REG_MSG_LEN = 1'b0;

    // One classified byte handed from the front to the back.
    typedef struct packed {
        logic [7:0]       data;
        logic [LEN_W-1:0] after;
        logic             final_byte;
        logic [LEN_W-1:0] rem;
        logic             restart;
    } t_cls;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      field_id;
        logic [2:0]       wire_kind;
        logic [63:0]      field_value;
        logic [LEN_W-1:0] payload_offset;
        logic             last;
    } t_res;
endpackage

// File: hdl/pwf_if.sv
// ----------------------------------------------------------------------------
// pwf_byte_if / pwf_res_if
// Valid/ready channels for input bytes and parsed fields.
// ----------------------------------------------------------------------------
interface pwf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface pwf_res_if;
    import pwf_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [31:0]       field_id;
    logic [2:0]        wire_kind;
    logic [63:0]       field_value;
    logic [LEN_W-1:0]  payload_offset;
    logic              last;
    modport source (output valid, output status, output field_id, output wire_kind,
                    output field_value, output payload_offset, output last, input ready);
    modport sink   (input valid, input status, input field_id, input wire_kind,
                    input field_value, input payload_offset, input last, output ready);
endinterface

// File: hdl/pwf_front.sv
// ----------------------------------------------------------------------------
// pwf_front
// Tracks the byte position in the message and tags each byte with its
// position, end-of-message flag and remaining byte count.
// ----------------------------------------------------------------------------
module pwf_front import pwf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [LEN_W-1:0] i_msg_len,
    input  logic             i_valid,
    input  logic [7:0]       i_data,
    output logic             o_ready,
    output logic             o_push,
    output t_cls             o_cls,
    input  logic             i_q_full
);
    logic [LEN_W-1:0] r_pos, n_pos, w_len, w_base;
    logic             r_pend, n_pend;
    logic             w_take;

    assign w_len   = (i_msg_len > LEN_W'(MAX_MSG)) ? LEN_W'(MAX_MSG) : i_msg_len;
    assign o_ready = !i_q_full;
    assign w_take  = i_valid && o_ready;
    assign w_base  = (r_pos >= w_len) ? '0 : r_pos;

    always_comb begin
        o_cls.data       = i_data;
        o_cls.after      = w_base + 1'b1;
        o_cls.final_byte = (o_cls.after == w_len);
        o_cls.rem        = w_len - o_cls.after;
        // A byte dropped at zero length or a lowered length restarts the decoder.
        o_cls.restart    = r_pend || (r_pos >= w_len);
        // A zero length drops every byte without a result.
        o_push = w_take && (w_len != '0);
        n_pos  = r_pos;
        n_pend = r_pend;
        if (w_take) begin
            n_pos  = (w_len == '0 || o_cls.final_byte) ? '0 : o_cls.after;
            n_pend = (w_len == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_pend <= n_pend;
        end
    end
endmodule

// File: hdl/pwf_queue.sv
// ----------------------------------------------------------------------------
// pwf_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module pwf_queue import pwf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cls o_data
);
    localparam int unsigned AW = $clog2(QDEPTH);
    t_cls          r_mem [QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

// File: hdl/pwf_back.sv
// ----------------------------------------------------------------------------
// pwf_back
// Field decoder: tag and value varints, fixed values, payload skipping and
// error handling, one byte per cycle unless an unaccepted result stalls it, into an output register.
// ----------------------------------------------------------------------------
module pwf_back import pwf_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  t_cls          i_cls,
    output logic          o_pop,
    pwf_res_if.source     res
);
    typedef enum logic [5:0] {
        PH_TAG    = 6'b000001,
        PH_VARINT = 6'b000010,
        PH_LEN    = 6'b000100,
        PH_FIXED  = 6'b001000,
        PH_SKIP   = 6'b010000,
        PH_IGNORE = 6'b100000
    } t_phase;

    t_phase           r_ph, n_ph, w_ph;
    logic [63:0]      r_acc, n_acc, w_acc, w_vacc;
    logic [3:0]       r_gc, n_gc, w_gc, w_vgc, w_n;
    logic [31:0]      r_fn, n_fn, w_fn;
    logic [2:0]       r_wt, n_wt, w_wt;
    logic [LEN_W-1:0] r_togo, n_togo, w_togo;
    logic             r_ov, w_fire, w_emit, w_vdone;
    t_res             r_res, w_res;
    logic [63:0]      w_rem64;

    assign o_pop  = !i_empty && (!r_ov || res.ready);
    assign w_fire = o_pop;
    assign w_rem64 = 64'(i_cls.rem);

    // A restarted message begins from the cleared parser state.
    assign w_ph   = i_cls.restart ? PH_TAG : r_ph;
    assign w_acc  = i_cls.restart ? '0 : r_acc;
    assign w_gc   = i_cls.restart ? '0 : r_gc;
    assign w_fn   = i_cls.restart ? '0 : r_fn;
    assign w_wt   = i_cls.restart ? '0 : r_wt;
    assign w_togo = i_cls.restart ? '0 : r_togo;

    // Varint group step on the current accumulator.
    assign w_n     = (w_gc < 4'(VARINT_MAX)) ? w_gc : 4'd0;
    assign w_vacc  = w_acc | (64'(i_cls.data[6:0]) << (7 * w_n));
    assign w_vgc   = w_n + 1'b1;
    assign w_vdone = !i_cls.data[7] || (w_vgc >= 4'(VARINT_MAX)) || i_cls.final_byte;

    always_comb begin
        logic [31:0] fn;
        logic [2:0]  wt;
        logic [3:0]  need;
        n_ph   = w_ph;
        n_acc  = w_acc;
        n_gc   = w_gc;
        n_fn   = w_fn;
        n_wt   = w_wt;
        n_togo = w_togo;
        w_emit = 1'b0;
        fn     = w_vacc[34:3];
        wt     = w_vacc[2:0];
        need   = (wt == WT_FIX64) ? 4'd8 : 4'd4;
        w_res  = '{status: ST_OK, field_id: w_fn, wire_kind: w_wt,
                   field_value: '0, payload_offset: '0, last: i_cls.final_byte};
        case (w_ph)
            PH_TAG: begin
                n_acc = w_vacc;
                n_gc  = w_vgc;
                if (w_vdone) begin
                    n_fn  = fn;
                    n_wt  = wt;
                    n_acc = '0;
                    n_gc  = '0;
                    w_res.field_id  = fn;
                    w_res.wire_kind = wt;
                    if (fn == '0) begin
                        w_emit = 1'b1;
                        w_res.status = ST_ZERO_FN;
                        n_ph = PH_IGNORE;
                    end else if (wt == WT_VARINT) begin
                        if (i_cls.final_byte) begin
                            w_emit = 1'b1;
                        end else begin
                            n_ph = PH_VARINT;
                        end
                    end else if (wt == WT_FIX64 || wt == WT_FIX32) begin
                        if (i_cls.rem < LEN_W'(need)) begin
                            w_emit = 1'b1;
                        end else begin
                            n_togo = LEN_W'(need);
                            n_ph   = PH_FIXED;
                        end
                    end else if (wt == WT_LEN) begin
                        if (i_cls.final_byte) begin
                            w_emit = 1'b1;
                            w_res.payload_offset = i_cls.after;
                        end else begin
                            n_ph = PH_LEN;
                        end
                    end else begin
                        w_emit = 1'b1;
                        w_res.status = ST_BAD_WT;
                        n_ph = PH_IGNORE;
                    end
                end
            end
            PH_VARINT: begin
                n_acc = w_vacc;
                n_gc  = w_vgc;
                if (w_vdone) begin
                    w_emit = 1'b1;
                    w_res.field_value = w_vacc;
                    n_acc = '0;
                    n_gc  = '0;
                    n_ph  = PH_TAG;
                end
            end
            PH_LEN: begin
                n_acc = w_vacc;
                n_gc  = w_vgc;
                if (w_vdone) begin
                    w_emit = 1'b1;
                    n_acc  = '0;
                    n_gc   = '0;
                    w_res.field_value    = w_vacc;
                    w_res.payload_offset = i_cls.after;
                    if (w_vacc > w_rem64) begin
                        w_res.status = ST_LEN_END;
                        n_ph = PH_IGNORE;
                    end else begin
                        n_togo = w_vacc[LEN_W-1:0];
                        n_ph   = (w_vacc == '0) ? PH_TAG : PH_SKIP;
                    end
                end
            end
            PH_FIXED: begin
                n_acc  = w_acc | (64'(i_cls.data) << (8 * w_gc[2:0]));
                n_gc   = w_gc + 1'b1;
                n_togo = w_togo - 1'b1;
                if (w_togo == LEN_W'(1)) begin
                    w_emit = 1'b1;
                    w_res.field_value = n_acc;
                    n_acc = '0;
                    n_gc  = '0;
                    n_ph  = PH_TAG;
                end
            end
            PH_SKIP: begin
                n_togo = w_togo - 1'b1;
                if (w_togo == LEN_W'(1)) begin
                    n_ph = PH_TAG;
                end
            end
            default: begin
            end
        endcase
        if (w_res.status != ST_OK) begin
            w_res.last = 1'b1;
        end
        // The message's final byte restarts the parser.
        if (i_cls.final_byte) begin
            n_ph   = PH_TAG;
            n_acc  = '0;
            n_gc   = '0;
            n_fn   = '0;
            n_wt   = '0;
            n_togo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_TAG;
            r_acc  <= '0;
            r_gc   <= '0;
            r_fn   <= '0;
            r_wt   <= '0;
            r_togo <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (w_fire) begin
                r_ph   <= n_ph;
                r_acc  <= n_acc;
                r_gc   <= n_gc;
                r_fn   <= n_fn;
                r_wt   <= n_wt;
                r_togo <= n_togo;
            end
            if (w_fire) begin
                r_ov <= w_emit;
            end else if (res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_res <= w_res;
        end
    end

    assign res.valid          = r_ov;
    assign res.status         = r_res.status;
    assign res.field_id       = r_res.field_id;
    assign res.wire_kind      = r_res.wire_kind;
    assign res.field_value    = r_res.field_value;
    assign res.payload_offset = r_res.payload_offset;
    assign res.last           = r_res.last;
endmodule

// File: hdl/protobuf_wire_field_parser_top.sv
// ----------------------------------------------------------------------------
// protobuf_wire_field_parser_top
// Protobuf wire format field parser with an APB register for message length.
// ----------------------------------------------------------------------------
// One byte is taken per cycle. A front stage tags each byte with its position
// in the message and feeds a two-entry queue; the back stage decodes one byte
// per cycle and registers the result, so the field a byte completes appears
// once that byte has passed the queue and the output register. The decoder
// stalls only when its output register is full and the sink holds off ready;
// the input drops ready once both queue entries are taken.
`include "protobuf_wire_field_parser_top_defines.svh"
module protobuf_wire_field_parser_top import pwf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    pwf_byte_if.sink    in_ch,
    pwf_res_if.source   out_ch
);
    logic [LEN_W-1:0] r_msg_len;
    logic             w_push, w_full, w_empty, w_pop;
    t_cls             w_in_cls, w_q_cls;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_MSG_LEN) ? 32'(r_msg_len) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_len <= '0;
        end else if (psel && penable && pwrite && paddr == REG_MSG_LEN) begin
            r_msg_len <= pwdata[LEN_W-1:0];
        end
    end

    pwf_front u_front (
        .i_clk, .i_rst_n, .i_msg_len(r_msg_len), .i_valid(in_ch.valid),
        .i_data(in_ch.data_byte), .o_ready(in_ch.ready), .o_push(w_push),
        .o_cls(w_in_cls), .i_q_full(w_full)
    );

    pwf_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_data(w_in_cls), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_data(w_q_cls)
    );

    pwf_back u_back (
        .i_clk, .i_rst_n, .i_empty(w_empty), .i_cls(w_q_cls), .o_pop(w_pop),
        .res(out_ch)
    );

    `PWF_ASSERT_IMPL(a_err_last, i_clk, i_rst_n,
        out_ch.valid && out_ch.status != ST_OK, out_ch.last,
        "error result without last")
    `PWF_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, w_pop, !w_empty,
        "queue popped while empty")
    `PWF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(out_ch.field_value),
        "stalled result changed")
endmodule
